[rtl/core/spcr_pkg.sv]
package spcr_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int NRM_BITS   = 14;
  localparam int NRM_ONE    = 16384;
  localparam int REST_BITS  = 16;
  localparam logic [16:0] REST_RESET = 17'd39322;
  localparam logic [16:0] REST_MAX   = 17'd65536;
  localparam logic [46:0] JCAP       = 47'h4000_0000_0000;

  localparam int FRONT_STAGES = 4;
  localparam int SQRT_STEPS   = 32;
  localparam int MU_STEPS     = 31;
  localparam int NRM_STEPS    = 15;
  localparam int NORM_STAGES  = NRM_STEPS + 1;
  localparam int IMP_STAGES   = 8;

  // everything one pair needs on its way through the pipe
  typedef struct packed {
    logic [15:0]       a_id;
    logic [15:0]       b_id;
    logic [2:0]        sneg;
    logic [2:0][31:0]  smag;
    logic [2:0][31:0]  dvel;
    logic [30:0]       ma;
    logic [30:0]       mb;
    logic [30:0]       ra;
    logic [30:0]       rb;
    logic [31:0]       msum;
    logic [31:0]       rsum;
    logic [2:0][63:0]  sq;
    logic [61:0]       prod;
    logic [63:0]       rsq;
    logic [63:0]       x;
    logic [63:0]       root;
    logic [31:0]       mrem;
    logic [30:0]       mu;
    logic [31:0]       dlen;
    logic [30:0]       depth;
    logic [2:0][31:0]  nrem;
    logic [2:0][14:0]  nnum;
    logic [2:0][14:0]  nq;
    logic [2:0][15:0]  nrm;
    logic [17:0]       fac;
    logic [32:0]       t;
    logic [2:0][47:0]  pv;
    logic [49:0]       vn;
    logic              vneg;
    logic [31:0]       vmag;
    logic [48:0]       plo;
    logic [48:0]       phi;
    logic [46:0]       jmag;
    logic [2:0][47:0]  comp;
    logic [2:0][31:0]  imp_a;
    logic [2:0][31:0]  imp_b;
  } item_t;

endpackage

[rtl/core/spcr_front.sv]
// magnitudes, squares, distance test
module spcr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_vld,
  input  spcr_pkg::item_t in_item,
  output logic           out_vld,
  output spcr_pkg::item_t out_item
);

  localparam int N = spcr_pkg::FRONT_STAGES;

  logic            vld [N];
  spcr_pkg::item_t stg [N];

  function automatic spcr_pkg::item_t step(input int k, input spcr_pkg::item_t d);
    spcr_pkg::item_t r;
    r = d;
    case (k)
      0: begin
        // smag carries the raw separation on entry
        for (int i = 0; i < 3; i++) begin
          r.sneg[i] = d.smag[i][31];
          r.smag[i] = d.smag[i][31] ? (32'd0 - d.smag[i]) : d.smag[i];
        end
        r.msum = {1'b0, d.ma} + {1'b0, d.mb};
        r.rsum = {1'b0, d.ra} + {1'b0, d.rb};
      end
      1: begin
        for (int i = 0; i < 3; i++) r.sq[i] = {32'd0, d.smag[i]} * {32'd0, d.smag[i]};
        r.prod = {31'd0, d.ma} * {31'd0, d.mb};
        r.rsq  = {32'd0, d.rsum} * {32'd0, d.rsum};
      end
      2: r.x = d.sq[0] + d.sq[1] + d.sq[2];
      3: begin
        r.root = 64'd0;
        r.mrem = {1'b0, d.prod[61:31]};
        r.mu   = 31'd0;
      end
      default: r = d;
    endcase
    return r;
  endfunction

  for (genvar k = 0; k < N; k++) begin : g_stg
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) vld[k] <= 1'b0;
        else if (adv) vld[k] <= in_vld;
        if (adv) stg[k] <= step(k, in_item);
      end
    end else if (k == N - 1) begin : g_hit
      // misses drop out here
      always_ff @(posedge clk) begin
        if (rst) vld[k] <= 1'b0;
        else if (adv) vld[k] <= vld[k-1] && (stg[k-1].x < stg[k-1].rsq);
        if (adv) stg[k] <= step(k, stg[k-1]);
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (rst) vld[k] <= 1'b0;
        else if (adv) vld[k] <= vld[k-1];
        if (adv) stg[k] <= step(k, stg[k-1]);
      end
    end
  end

  assign out_vld  = vld[N-1];
  assign out_item = stg[N-1];

endmodule

[rtl/core/spcr_root.sv]
// square root and reduced-mass division, one bit per stage each
module spcr_root (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_vld,
  input  spcr_pkg::item_t in_item,
  output logic           out_vld,
  output spcr_pkg::item_t out_item
);

  localparam int N = spcr_pkg::SQRT_STEPS;

  logic            vld [N];
  spcr_pkg::item_t stg [N];

  function automatic spcr_pkg::item_t step(input int k, input spcr_pkg::item_t d);
    spcr_pkg::item_t r;
    logic [63:0]     bitv;
    logic [63:0]     trial;
    logic [32:0]     r2;
    r     = d;
    bitv  = 64'd1 << (62 - 2 * k);
    trial = d.root + bitv;
    if (d.x >= trial) begin
      r.x    = d.x - trial;
      r.root = (d.root >> 1) + bitv;
    end else begin
      r.root = d.root >> 1;
    end
    if (k < spcr_pkg::MU_STEPS) begin
      r2 = {d.mrem, d.prod[spcr_pkg::MU_STEPS - 1 - k]};
      if (r2 >= {1'b0, d.msum}) begin
        r.mrem = r2[31:0] - d.msum;
        r.mu[spcr_pkg::MU_STEPS - 1 - k] = 1'b1;
      end else begin
        r.mrem = r2[31:0];
      end
    end
    return r;
  endfunction

  for (genvar k = 0; k < N; k++) begin : g_stg
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) vld[k] <= 1'b0;
        else if (adv) vld[k] <= in_vld;
        if (adv) stg[k] <= step(k, in_item);
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) vld[k] <= 1'b0;
        else if (adv) vld[k] <= vld[k-1];
        if (adv) stg[k] <= step(k, stg[k-1]);
      end
    end
  end

  assign out_vld  = vld[N-1];
  assign out_item = stg[N-1];

endmodule

[rtl/core/spcr_norm.sv]
// depth and rounded normal magnitudes, three dividers in lockstep
module spcr_norm (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_vld,
  input  spcr_pkg::item_t in_item,
  output logic           out_vld,
  output spcr_pkg::item_t out_item
);

  localparam int N = spcr_pkg::NORM_STAGES;

  logic            vld [N];
  spcr_pkg::item_t stg [N];

  function automatic spcr_pkg::item_t step(input int k, input spcr_pkg::item_t d);
    spcr_pkg::item_t r;
    logic [31:0]     dl;
    logic [45:0]     num;
    logic [32:0]     r2;
    r = d;
    if (k == 0) begin
      dl      = d.root[31:0];
      r.dlen  = dl;
      r.depth = 31'((d.rsum - dl) >> 1);
      r.mu    = (d.msum == 32'd0) ? 31'd0 : d.mu;
      for (int i = 0; i < 3; i++) begin
        num       = {d.smag[i], 14'd0} + {15'd0, dl[31:1]};
        r.nrem[i] = {1'b0, num[45:15]};
        r.nnum[i] = num[14:0];
        r.nq[i]   = 15'd0;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        r2 = {d.nrem[i], d.nnum[i][spcr_pkg::NRM_STEPS - k]};
        if (r2 >= {1'b0, d.dlen}) begin
          r.nrem[i] = r2[31:0] - d.dlen;
          r.nq[i][spcr_pkg::NRM_STEPS - k] = 1'b1;
        end else begin
          r.nrem[i] = r2[31:0];
        end
      end
    end
    return r;
  endfunction

  for (genvar k = 0; k < N; k++) begin : g_stg
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) vld[k] <= 1'b0;
        else if (adv) vld[k] <= in_vld;
        if (adv) stg[k] <= step(k, in_item);
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) vld[k] <= 1'b0;
        else if (adv) vld[k] <= vld[k-1];
        if (adv) stg[k] <= step(k, stg[k-1]);
      end
    end
  end

  assign out_vld  = vld[N-1];
  assign out_item = stg[N-1];

endmodule

[rtl/core/spcr_impulse.sv]
// closing speed, impulse scalar and saturated components
module spcr_impulse (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic [16:0]    restitution,
  input  logic           in_vld,
  input  spcr_pkg::item_t in_item,
  output logic           out_vld,
  output spcr_pkg::item_t out_item
);

  localparam int N = spcr_pkg::IMP_STAGES;

  logic            vld [N];
  spcr_pkg::item_t stg [N];

  function automatic logic [31:0] sat32(input logic neg, input logic [47:0] m);
    logic [31:0] r;
    if (m == 48'd0) r = 32'd0;
    else if (neg) r = (m > 48'h8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
    else r = (m > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    return r;
  endfunction

  function automatic spcr_pkg::item_t step(input int k, input spcr_pkg::item_t d,
                                           input logic [16:0] e);
    spcr_pkg::item_t r;
    logic [16:0]     ec;
    logic [48:0]     tf;
    logic [49:0]     av;
    logic [35:0]     sh;
    logic [64:0]     full;
    logic [64:0]     jr;
    logic [61:0]     cp;
    logic            neg;
    r = d;
    case (k)
      0: begin
        ec    = (e > spcr_pkg::REST_MAX) ? spcr_pkg::REST_MAX : e;
        r.fac = 18'd65536 + {1'b0, ec};
        for (int i = 0; i < 3; i++) begin
          if (d.dlen == 32'd0) begin
            r.nq[i]  = (i == 0) ? 15'(spcr_pkg::NRM_ONE) : 15'd0;
            r.nrm[i] = (i == 0) ? 16'(spcr_pkg::NRM_ONE) : 16'd0;
          end else begin
            r.nrm[i] = d.sneg[i] ? (16'd0 - {1'b0, d.nq[i]}) : {1'b0, d.nq[i]};
          end
        end
      end
      1: begin
        for (int i = 0; i < 3; i++)
          r.pv[i] = 48'($signed(d.dvel[i]) * $signed(d.nrm[i]));
        tf  = {31'd0, d.fac} * {18'd0, d.mu};
        r.t = 33'(tf >> spcr_pkg::REST_BITS);
      end
      2: r.vn = {{2{d.pv[0][47]}}, d.pv[0]} + {{2{d.pv[1][47]}}, d.pv[1]}
              + {{2{d.pv[2][47]}}, d.pv[2]};
      3: begin
        r.vneg = d.vn[49];
        av     = d.vn[49] ? (50'd0 - d.vn) : d.vn;
        sh     = 36'(av >> spcr_pkg::NRM_BITS);
        r.vmag = (sh > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : sh[31:0];
      end
      4: begin
        r.plo = {16'd0, d.t} * {33'd0, d.vmag[15:0]};
        r.phi = {16'd0, d.t} * {33'd0, d.vmag[31:16]};
      end
      5: begin
        full   = {d.phi, 16'd0} + {16'd0, d.plo};
        jr     = full >> spcr_pkg::FRAC_BITS;
        r.jmag = (jr > {18'd0, spcr_pkg::JCAP}) ? spcr_pkg::JCAP : jr[46:0];
      end
      6: begin
        for (int i = 0; i < 3; i++) begin
          cp        = {15'd0, d.jmag} * {47'd0, d.nq[i]};
          r.comp[i] = 48'(cp >> spcr_pkg::NRM_BITS);
        end
      end
      7: begin
        for (int i = 0; i < 3; i++) begin
          neg        = d.vneg != d.nrm[i][15];
          r.imp_a[i] = sat32(neg, d.comp[i]);
          r.imp_b[i] = sat32(!neg, d.comp[i]);
        end
      end
      default: r = d;
    endcase
    return r;
  endfunction

  for (genvar k = 0; k < N; k++) begin : g_stg
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) vld[k] <= 1'b0;
        else if (adv) vld[k] <= in_vld;
        if (adv) stg[k] <= step(k, in_item, restitution);
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) vld[k] <= 1'b0;
        else if (adv) vld[k] <= vld[k-1];
        if (adv) stg[k] <= step(k, stg[k-1], restitution);
      end
    end
  end

  assign out_vld  = vld[N-1];
  assign out_item = stg[N-1];

endmodule

[rtl/core/spcr_out.sv]
// holds one pair and shows its two records, A then B
module spcr_out (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_vld,
  input  spcr_pkg::item_t in_item,
  input  logic           out_stall,
  output logic           adv,
  output logic           out_valid,
  output logic           phase,
  output spcr_pkg::item_t hold
);

  logic hvld;

  // free when empty or when the B word leaves now
  assign adv       = !hvld || (phase && !out_stall);
  assign out_valid = hvld;

  always_ff @(posedge clk) begin
    if (rst) begin
      hvld  <= 1'b0;
      phase <= 1'b0;
    end else if (adv) begin
      hvld  <= in_vld;
      phase <= 1'b0;
    end else if (!out_stall) begin
      phase <= 1'b1;
    end
    if (adv) hold <= in_item;
  end

endmodule

[rtl/core/sphere_pair_collision_response_top.sv]
// Sphere pair collision response. Each input word is one pair of spheres
// (separation and relative velocity B minus A, masses and radii in Q16.16, ids).
// A pair whose squared distance is below the squared radius sum gives two
// output words, A first, then B with last set; a miss gives nothing. Each word
// carries a Q2.14 unit normal toward the other body (+x for coincident
// centres), the own radius, half the overlap, and the saturated impulse
// (1+e)*mu*((vB-vA).n)*n, negated for B. A new pair enters every cycle while
// the pipe is not stalled; the output stage holds the pipe while it shows the
// A word of a hit. The 32-step square root and the reduced-mass divider run
// side by side, one bit per stage, followed by three 15-step normal dividers
// and the impulse multipliers. A stall on the output holds the whole pipe.
// The restitution register (Q1.16, reset 0.6, clamped to 1.0) is written
// through the cfg port, always ready; the user must write it only while the
// block is idle, as the block itself does not enforce this.
module sphere_pair_collision_response_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_restitution,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] obj_a_id,
  input  logic [15:0] obj_b_id,
  input  logic signed [31:0] sep_x,
  input  logic signed [31:0] sep_y,
  input  logic signed [31:0] sep_z,
  input  logic signed [31:0] dvel_x,
  input  logic signed [31:0] dvel_y,
  input  logic signed [31:0] dvel_z,
  input  logic [30:0] mass_a,
  input  logic [30:0] mass_b,
  input  logic [30:0] radius_a,
  input  logic [30:0] radius_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] object_id,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic [30:0] contact_offset,
  output logic [30:0] push_depth,
  output logic signed [31:0] impulse_x,
  output logic signed [31:0] impulse_y,
  output logic signed [31:0] impulse_z,
  output logic        last
);

  logic [16:0]     restitution;
  logic            adv;
  spcr_pkg::item_t ent;
  logic            f_vld, r_vld, n_vld, i_vld;
  spcr_pkg::item_t f_item, r_item, n_item, i_item;
  spcr_pkg::item_t hold;
  logic            phase;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) restitution <= spcr_pkg::REST_RESET;
    else if (cfg_valid && cfg_ready) restitution <= cfg_restitution;
  end

  // entry word; smag holds the raw separation until the first stage
  always_comb begin
    ent      = '0;
    ent.a_id = obj_a_id;
    ent.b_id = obj_b_id;
    ent.smag = {sep_z, sep_y, sep_x};
    ent.dvel = {dvel_z, dvel_y, dvel_x};
    ent.ma   = mass_a;
    ent.mb   = mass_b;
    ent.ra   = radius_a;
    ent.rb   = radius_b;
  end

  assign in_stall = !adv;

  spcr_front u_front (
    .clk, .rst, .adv,
    .in_vld(in_valid), .in_item(ent),
    .out_vld(f_vld), .out_item(f_item)
  );

  spcr_root u_root (
    .clk, .rst, .adv,
    .in_vld(f_vld), .in_item(f_item),
    .out_vld(r_vld), .out_item(r_item)
  );

  spcr_norm u_norm (
    .clk, .rst, .adv,
    .in_vld(r_vld), .in_item(r_item),
    .out_vld(n_vld), .out_item(n_item)
  );

  spcr_impulse u_imp (
    .clk, .rst, .adv, .restitution,
    .in_vld(n_vld), .in_item(n_item),
    .out_vld(i_vld), .out_item(i_item)
  );

  spcr_out u_out (
    .clk, .rst,
    .in_vld(i_vld), .in_item(i_item),
    .out_stall, .adv, .out_valid, .phase, .hold
  );

  // B gets the negated normal and its own saturated impulse
  assign object_id      = phase ? hold.b_id : hold.a_id;
  assign normal_x       = phase ? (16'sd0 - hold.nrm[0]) : hold.nrm[0];
  assign normal_y       = phase ? (16'sd0 - hold.nrm[1]) : hold.nrm[1];
  assign normal_z       = phase ? (16'sd0 - hold.nrm[2]) : hold.nrm[2];
  assign contact_offset = phase ? hold.rb : hold.ra;
  assign push_depth     = hold.depth;
  assign impulse_x      = phase ? hold.imp_b[0] : hold.imp_a[0];
  assign impulse_y      = phase ? hold.imp_b[1] : hold.imp_a[1];
  assign impulse_z      = phase ? hold.imp_b[2] : hold.imp_a[2];
  assign last           = phase;

endmodule

[rtl/core/spcr_checker.sv]
module spcr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic signed [15:0] normal_x,
  input logic        last
);

  // a waiting word stays up
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // an A word is always followed by its B word
  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid && last)
    else $error("A record not followed by B record");

  // input only waits on a full output stage
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_nrm: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (normal_x <= 16'sd16384) && (normal_x >= -16'sd16384))
    else $error("normal out of range");

endmodule

bind sphere_pair_collision_response_top spcr_checker u_chk (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .normal_x, .last
);

[tb/sv/sphere_pair_collision_response_top_test.sv]
module sphere_pair_collision_response_top_test;

  // one sphere pair as it goes onto the input channel
  typedef struct {
    logic [15:0]        a_id;
    logic [15:0]        b_id;
    logic signed [31:0] sep [3];
    logic signed [31:0] dvel [3];
    logic [30:0]        ma;
    logic [30:0]        mb;
    logic [30:0]        ra;
    logic [30:0]        rb;
  } pair_t;

  // one contact record as it leaves the block
  typedef struct {
    logic [15:0]        id;
    logic signed [15:0] nrm [3];
    logic [30:0]        offset;
    logic [30:0]        depth;
    logic signed [31:0] imp [3];
    logic               last;
  } contact_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 80;   // misses leave no trace, so wait out the pipe

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] cfg_restitution = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] obj_a_id = '0, obj_b_id = '0;
  logic signed [31:0] sep_x = '0, sep_y = '0, sep_z = '0;
  logic signed [31:0] dvel_x = '0, dvel_y = '0, dvel_z = '0;
  logic [30:0] mass_a = '0, mass_b = '0, radius_a = '0, radius_b = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [15:0] object_id;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic [30:0] contact_offset, push_depth;
  logic signed [31:0] impulse_x, impulse_y, impulse_z;
  logic        last;

  sphere_pair_collision_response_top i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_restitution(cfg_restitution),
    .in_valid(in_valid), .in_stall(in_stall),
    .obj_a_id(obj_a_id), .obj_b_id(obj_b_id),
    .sep_x(sep_x), .sep_y(sep_y), .sep_z(sep_z),
    .dvel_x(dvel_x), .dvel_y(dvel_y), .dvel_z(dvel_z),
    .mass_a(mass_a), .mass_b(mass_b), .radius_a(radius_a), .radius_b(radius_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .object_id(object_id), .normal_x(normal_x), .normal_y(normal_y),
    .normal_z(normal_z), .contact_offset(contact_offset), .push_depth(push_depth),
    .impulse_x(impulse_x), .impulse_y(impulse_y), .impulse_z(impulse_z),
    .last(last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  pair_t       pairs_to_send [$];    // pending input words
  contact_t    contacts_due [$];     // records the block still owes us
  pair_t       pair_on_bus;
  logic [16:0] restitution_q = spcr_pkg::REST_RESET;
  logic        calm = 1'b0;          // no idling on either side
  logic        pair_taken = 1'b0;
  int          errors = 0;
  int          quiet_cycles = 0;

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned abs64(longint signed v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] clamp_impulse(bit neg, longint unsigned m);
    if (neg) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return 32'(0 - m);
    end
    if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
    return 32'(m);
  endfunction

  // contact records for one pair; a miss yields none
  task automatic predict_contacts(pair_t p);
    longint unsigned d2, rsum, dlen, depth, msum, mu, e, t, vmag, jmag, q, comp;
    longint signed   s [3], dv [3], n [3];
    longint signed   vn;
    bit              vneg, neg;
    contact_t        c;
    d2 = 0;
    vn = 0;
    for (int i = 0; i < 3; i++) begin
      s[i]  = p.sep[i];
      dv[i] = p.dvel[i];
      d2 += abs64(s[i]) * abs64(s[i]);
    end
    rsum = longint'(p.ra) + longint'(p.rb);
    if (d2 >= rsum * rsum) return;
    dlen = int_sqrt(d2);
    // coincident centres push along +x
    if (dlen == 0) begin
      n[0] = spcr_pkg::NRM_ONE;
      n[1] = 0;
      n[2] = 0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        q = (abs64(s[i]) * spcr_pkg::NRM_ONE + dlen / 2) / dlen;
        n[i] = s[i] < 0 ? -longint'(q) : longint'(q);
      end
    end
    depth = (rsum - dlen) >> 1;
    msum = longint'(p.ma) + longint'(p.mb);
    mu = msum == 0 ? 0 : (longint'(p.ma) * longint'(p.mb)) / msum;
    e = restitution_q > spcr_pkg::REST_MAX ? spcr_pkg::REST_MAX : restitution_q;
    t = ((64'd65536 + e) * mu) >> 16;
    for (int i = 0; i < 3; i++) vn += dv[i] * n[i];
    vneg = vn < 0;
    vmag = abs64(vn) >> spcr_pkg::NRM_BITS;
    if (vmag > 64'hFFFF_FFFF) vmag = 64'hFFFF_FFFF;
    jmag = (t * vmag) >> spcr_pkg::FRAC_BITS;
    if (jmag > 64'd1 << 46) jmag = 64'd1 << 46;
    for (int k = 0; k < 2; k++) begin
      c.id = k == 0 ? p.a_id : p.b_id;
      for (int i = 0; i < 3; i++) begin
        comp = (jmag * abs64(n[i])) >> spcr_pkg::NRM_BITS;
        neg = (vneg != (n[i] < 0)) ^ (k == 1);
        c.nrm[i] = 16'(k == 0 ? n[i] : -n[i]);
        c.imp[i] = comp == 0 ? 32'd0 : clamp_impulse(neg, comp);
      end
      c.offset = k == 0 ? p.ra : p.rb;
      c.depth = 31'(depth);
      c.last = k[0];
      contacts_due.insert(contacts_due.size(), c);
    end
  endtask

  // ----------------------------------------------------------------- checking

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d, want %0d (t=%0t)", what, got, want, $time);
    errors++;
  endtask

  task automatic check_contact(contact_t got);
    contact_t w;
    if (contacts_due.size() == 0) begin
      report("unexpected word, id", got.id, -1);
      return;
    end
    w = contacts_due.pop_front();
    if (got.id !== w.id) report("object_id", got.id, w.id);
    for (int i = 0; i < 3; i++) begin
      if (got.nrm[i] !== w.nrm[i]) report($sformatf("normal[%0d]", i), got.nrm[i], w.nrm[i]);
      if (got.imp[i] !== w.imp[i]) report($sformatf("impulse[%0d]", i), got.imp[i], w.imp[i]);
    end
    if (got.offset !== w.offset) report("contact_offset", got.offset, w.offset);
    if (got.depth !== w.depth) report("push_depth", got.depth, w.depth);
    if (got.last !== w.last) report("last", got.last, w.last);
  endtask

  // monitor: input accepts feed the predictor, output accepts are checked
  always @(posedge clk) begin
    contact_t got;
    pair_taken = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_contacts(pair_on_bus);
        pair_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got.id = object_id;
        got.nrm[0] = normal_x;
        got.nrm[1] = normal_y;
        got.nrm[2] = normal_z;
        got.offset = contact_offset;
        got.depth = push_depth;
        got.imp[0] = impulse_x;
        got.imp[1] = impulse_y;
        got.imp[2] = impulse_z;
        got.last = last;
        check_contact(got);
      end
      // watchdog: any word moving on any channel counts as progress
      if (pair_taken || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------- driver

  // new word only after the previous one went through; payload held on stall
  always @(negedge clk) begin
    if (!rst) begin
      out_stall <= !calm && $urandom_range(99) < 10;
      if (!in_valid || pair_taken) begin
        if (pairs_to_send.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
          pair_on_bus = pairs_to_send.pop_front();
          in_valid <= 1'b1;
          obj_a_id <= pair_on_bus.a_id;
          obj_b_id <= pair_on_bus.b_id;
          sep_x <= pair_on_bus.sep[0];
          sep_y <= pair_on_bus.sep[1];
          sep_z <= pair_on_bus.sep[2];
          dvel_x <= pair_on_bus.dvel[0];
          dvel_y <= pair_on_bus.dvel[1];
          dvel_z <= pair_on_bus.dvel[2];
          mass_a <= pair_on_bus.ma;
          mass_b <= pair_on_bus.mb;
          radius_a <= pair_on_bus.ra;
          radius_b <= pair_on_bus.rb;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic longint unsigned rbits(int n);
    longint unsigned x;
    x = {$urandom, $urandom};
    return n <= 0 ? 64'd0 : x >> (64 - n);
  endfunction

  task automatic add_pair(longint a, longint b,
                          longint sx, longint sy, longint sz,
                          longint vx, longint vy, longint vz,
                          longint ma, longint mb, longint ra, longint rb);
    pair_t p;
    p.a_id = 16'(a);
    p.b_id = 16'(b);
    p.sep[0] = 32'(sx);
    p.sep[1] = 32'(sy);
    p.sep[2] = 32'(sz);
    p.dvel[0] = 32'(vx);
    p.dvel[1] = 32'(vy);
    p.dvel[2] = 32'(vz);
    p.ma = 31'(ma);
    p.mb = 31'(mb);
    p.ra = 31'(ra);
    p.rb = 31'(rb);
    pairs_to_send.insert(pairs_to_send.size(), p);
  endtask

  function automatic longint rand_within(longint unsigned lim);
    longint v;
    v = longint'(rbits(40) % (lim + 1));
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic longint rand_vel();
    logic signed [31:0] v;
    v = 32'(rbits(32));
    return v >>> $urandom_range(31, 0);
  endfunction

  task automatic add_random_pair();
    int             kind, sh;
    longint unsigned ra, rb, rsum;
    longint         ax;
    kind = $urandom_range(99);
    sh = $urandom_range(29, 4);
    ra = rbits(sh);
    rb = rbits(sh);
    if (ra + rb == 0) ra = 1;
    rsum = ra + rb;
    if (kind < 70) begin
      // overlapping spheres, each axis within half the radius sum
      add_pair(rbits(16), rbits(16), rand_within(rsum / 2), rand_within(rsum / 2),
               rand_within(rsum / 2), rand_vel(), rand_vel(), rand_vel(),
               rbits($urandom_range(31, 1)) | 1, rbits($urandom_range(31, 1)) | 1, ra, rb);
    end else if (kind < 85) begin
      // anything the ports allow, mostly misses
      add_pair(rbits(16), rbits(16), rbits(32), rbits(32), rbits(32),
               rbits(32), rbits(32), rbits(32),
               rbits(31) | 1, rbits(31) | 1, rbits(31), rbits(31));
    end else if (kind < 93) begin
      // just touching (miss) or one step inside, on a random axis
      ax = $urandom_range(1) ? longint'(rsum) : longint'(rsum) - 1;
      if ($urandom_range(1)) ax = -ax;
      case ($urandom_range(2))
        0: add_pair(rbits(16), rbits(16), ax, 0, 0, rand_vel(), rand_vel(), rand_vel(),
                    rbits(24) | 1, rbits(24) | 1, ra, rb);
        1: add_pair(rbits(16), rbits(16), 0, ax, 0, rand_vel(), rand_vel(), rand_vel(),
                    rbits(24) | 1, rbits(24) | 1, ra, rb);
        default: add_pair(rbits(16), rbits(16), 0, 0, ax, rand_vel(), rand_vel(),
                          rand_vel(), rbits(24) | 1, rbits(24) | 1, ra, rb);
      endcase
    end else begin
      // coincident or nearly so
      add_pair(rbits(16), rbits(16), rand_within(1), rand_within(1), 0,
               rand_vel(), rand_vel(), rand_vel(), rbits(31) | 1, rbits(31) | 1, ra, rb);
    end
  endtask

  // block idle: nothing queued, nothing owed, pipe flushed of misses
  task automatic wait_idle();
    while (pairs_to_send.size() != 0 || in_valid || contacts_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_restitution(logic [16:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_restitution <= value;
    do @(posedge clk); while (!cfg_ready);
    restitution_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  localparam longint MAXR = 64'h7FFF_FFFF;
  localparam longint MINS = -64'sh8000_0000;
  localparam longint MAXS = 64'sh7FFF_FFFF;

  initial begin
    logic [16:0] settings [4];
    settings[0] = 17'd0;
    settings[1] = spcr_pkg::REST_MAX;
    settings[2] = 17'h1FFFF;   // above one, block clamps
    settings[3] = 17'($urandom_range(65536));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed pairs, reset restitution
    add_pair(16'h0000, 16'hFFFF, 0, 0, 0, 65536, 0, 0, 65536, 65536, 65536, 65536);
    add_pair(16'h1234, 16'h4321, 0, 0, 0, 0, 0, 0, 65536, 65536, 0, 0);       // zero radii miss
    add_pair(16'hFFFF, 16'h0000, MINS, MINS, MINS, MAXS, MINS, MAXS,
             MAXR, MAXR, MAXR, MAXR);                                         // all maximal
    add_pair(1, 2, MAXS, MAXS, MAXS, MINS, MAXS, MINS, MAXR, MAXR, MAXR, MAXR);
    add_pair(3, 4, 65536, 0, 0, -(64'sd1 << 20), 0, 0, 0, 0, 131072, 131072); // zero masses
    add_pair(5, 6, 65536, 0, 0, -(64'sd1 << 20), 0, 0, 1, 1, 131072, 131072); // minimal masses
    add_pair(7, 8, 262144, 0, 0, 0, 0, 0, 65536, 65536, 131072, 131072);      // touching
    add_pair(9, 10, 262143, 0, 0, 65536, 0, 0, 65536, 65536, 131072, 131072); // just inside
    add_pair(11, 12, 0, -100000, 0, 0, MAXS, 0, MAXR, MAXR, 65536, 65536);
    add_pair(13, 14, 0, 0, -100000, 0, 0, MINS, MAXR, MAXR, 65536, 65536);
    add_pair(15, 16, -100000, 0, 0, MINS, 0, 0, MAXR, MAXR, 65536, 65536);
    add_pair(17, 18, 40000, -40000, 40000, 123456, -654321, 77777,
             300000, 200000, 65536, 65536);
    add_pair(19, 20, 1, 1, 1, MAXS, MAXS, MAXS, MAXR, 1, 1, 1);
    add_pair(21, 22, 3, -4, 0, -5, 7, 9, MAXR, MAXR, 3, 3);
    add_pair(23, 24, 0, 0, 0, 0, 0, 0, MAXR, MAXR, MAXR, 0);                  // coincident, idle
    for (int i = 0; i < 300; i++) add_random_pair();
    wait_idle();

    // one setting per phase; the second phase runs without idling
    for (int ph = 0; ph < 4; ph++) begin
      write_restitution(settings[ph]);
      calm = ph == 1;
      for (int i = 0; i < 330; i++) add_random_pair();
      wait_idle();
    end
    calm = 1'b0;

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
